/* rtl/nvdz_pkg.sv */
// Shared types and constants for the nearest-vertex longitudinal dz selector.
package nvdz_pkg;

    // register map of the configuration port
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z   = 3'd5;

    // selection cuts (integer part, scaled by the fraction width at use)
    localparam int NDOF_MIN  = 4;    // ndof must exceed this
    localparam int Z_MAX     = 24;   // |z| below this, cm
    localparam int R2_MAX    = 4;    // x^2 + y^2 below this, cm^2
    localparam int DZ_INIT   = 999;  // kept dz after reset, cm

    // quotient saturates at 2^CAP_SHIFT
    localparam int CAP_SHIFT = 40;

    // top-level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_UPD,
        S_OUT
    } state_t;

    // multiplier passes, one per cycle
    typedef enum logic [3:0] {
        MS_XX,
        MS_YY,
        MS_PXX,
        MS_PYY,
        MS_DXP,
        MS_DYP,
        MS_NUM,
        MS_PLO,
        MS_PHI
    } mstep_t;

endpackage

/* rtl/nvdz_if.sv */
// Valid/ready channels for vertex input words and result words.
interface nvdz_vtx_if #(
    parameter int WORD_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] vtx_x;
    logic [WORD_BITS-1:0] vtx_y;
    logic [WORD_BITS-1:0] vtx_z;
    logic [WORD_BITS-1:0] vtx_ndof;
    logic                 last;

    modport source (output valid, vtx_x, vtx_y, vtx_z, vtx_ndof, last, input ready);
    modport sink   (input valid, vtx_x, vtx_y, vtx_z, vtx_ndof, last, output ready);
endinterface

interface nvdz_res_if #(
    parameter int WORD_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] best_x;
    logic [WORD_BITS-1:0] best_y;
    logic [WORD_BITS-1:0] best_z;
    logic [WORD_BITS-1:0] best_dz;
    logic                 found;

    modport source (output valid, best_x, best_y, best_z, best_dz, found, input ready);
    modport sink   (input valid, best_x, best_y, best_z, best_dz, found, output ready);
endinterface

/* rtl/nvdz_mul.sv */
// Shared unsigned multiplier used by every product of the sequencer.
module nvdz_mul #(
    parameter int MW = 33
) (
    input  logic [MW-1:0]   a,
    input  logic [MW-1:0]   b,
    output logic [2*MW-1:0] p
);
    assign p = (2*MW)'(a) * (2*MW)'(b);
endmodule

/* rtl/nvdz_div.sv */
// Restoring divider, one quotient bit per cycle, saturating quotient.
module nvdz_div
    import nvdz_pkg::*;
#(
    parameter int PW = 99,
    parameter int RW = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PW-1:0]      num,
    input  logic [RW-1:0]      den,
    output logic               done,
    output logic [CAP_SHIFT:0] quot
);
    localparam int QB = CAP_SHIFT;
    localparam int CW = $clog2(QB + 1);

    logic [RW-1:0]   rem_reg, rem_next;
    logic [QB-1:0]   low_reg, low_next;
    logic [QB:0]     quot_reg, quot_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;

    always_comb
    begin
        logic [RW:0] trial;
        trial     = {rem_reg, low_reg[QB-1]};
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            // quotient would reach the cap: saturate at once
            if ((num >> QB) >= PW'(den))
            begin
                quot_next = (QB+1)'(1) << QB;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = RW'(num >> QB);
                low_next  = num[QB-1:0];
                quot_next = '0;
                cnt_next  = CW'(QB);
                run_next  = 1'b1;
            end
        end
        else if (run_reg)
        begin
            if (trial >= (RW+1)'(den))
            begin
                rem_next  = RW'(trial - (RW+1)'(den));
                quot_next = {quot_reg[QB-1:0], 1'b1};
            end
            else
            begin
                rem_next  = RW'(trial);
                quot_next = {quot_reg[QB-1:0], 1'b0};
            end
            low_next = {low_reg[QB-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

/* rtl/nearest_vertex_by_longitudinal_dz.sv */
// Sequence per accepted vertex word: the multiplier passes, the divider start,
// the 40 divider steps, the done cycle and the update; the divider steps are
// skipped when the quotient saturates. A vertex word is accepted only in idle,
// so a new vertex waits until the last one is through; the pace is set by the
// 40-step serial divider and the single shared multiplier. A last word adds the
// result hand-off, which waits for res.ready. Reset: config registers zero, kept
// vertex zero, kept dz 999.0, no result.
module nearest_vertex_by_longitudinal_dz
    import nvdz_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]    cfg_data,
    nvdz_vtx_if.sink                vtx,
    nvdz_res_if.source              res
);
    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int MW  = W + 1;
    localparam int PRW = 2 * MW;
    localparam int PW  = 3 * MW;
    localparam int RW  = 2 * W;
    localparam int QB  = CAP_SHIFT;
    localparam int DZW = ((MW > QB + 1) ? MW : QB + 1) + 1;
    localparam int CW  = 2 * W + 2 * F + 8;

    localparam logic signed [CW-1:0] NDOF_LIM = CW'(NDOF_MIN) <<< F;
    localparam logic [CW-1:0]        Z_LIM    = CW'(Z_MAX) << F;
    localparam logic [CW-1:0]        R2_LIM   = CW'(R2_MAX) << (2 * F);
    localparam logic signed [DZW-1:0] DZ_RST  = DZW'(DZ_INIT) <<< F;

    function automatic logic [MW-1:0] mag_f(input logic signed [MW-1:0] v);
        mag_f = v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    // configuration registers
    logic signed [W-1:0] lx_reg, ly_reg, lz_reg, px_reg, py_reg, pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg <= '0;
            ly_reg <= '0;
            lz_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POINT_X: lx_reg <= cfg_data;
                REG_POINT_Y: ly_reg <= cfg_data;
                REG_POINT_Z: lz_reg <= cfg_data;
                REG_DIR_X:   px_reg <= cfg_data;
                REG_DIR_Y:   py_reg <= cfg_data;
                REG_DIR_Z:   pz_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    mstep_t              step_reg, step_next;
    logic signed [W-1:0] x_reg, y_reg, z_reg, ndof_reg;
    logic                last_reg;
    logic [RW-1:0]       r2_reg, r2_next, pt2_reg, pt2_next;
    logic [PRW-1:0]      m1_reg, m1_next, m2_reg, m2_next;
    logic                n1_reg, n1_next, n2_reg, n2_next, nn_reg, nn_next;
    logic [PRW:0]        nm_reg, nm_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic signed [DZW-1:0] kdz_reg, kdz_next;
    logic signed [W-1:0] kx_reg, kx_next, ky_reg, ky_next, kz_reg, kz_next;
    logic                have_reg, have_next;
    logic [W-1:0]        ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next, odz_reg, odz_next;
    logic                of_reg, of_next;
    logic                div_start;

    // operands
    logic [MW-1:0]   ax, ay, apx, apy, apz, adx, ady;
    logic            dx_neg, dy_neg;
    logic [MW-1:0]   mul_a, mul_b;
    logic [PRW-1:0]  mul_p;
    logic            div_done;
    logic [QB:0]     div_q;

    assign ax  = mag_f(MW'(x_reg));
    assign ay  = mag_f(MW'(y_reg));
    assign apx = mag_f(MW'(px_reg));
    assign apy = mag_f(MW'(py_reg));
    assign apz = mag_f(MW'(pz_reg));

    always_comb
    begin
        logic signed [MW-1:0] dx, dy;
        dx     = MW'(lx_reg) - MW'(x_reg);
        dy     = MW'(ly_reg) - MW'(y_reg);
        adx    = mag_f(dx);
        ady    = mag_f(dy);
        dx_neg = dx[MW-1];
        dy_neg = dy[MW-1];
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            MS_XX:  begin mul_a = ax;  mul_b = ax;  end
            MS_YY:  begin mul_a = ay;  mul_b = ay;  end
            MS_PXX: begin mul_a = apx; mul_b = apx; end
            MS_PYY: begin mul_a = apy; mul_b = apy; end
            MS_DXP: begin mul_a = adx; mul_b = apx; end
            MS_DYP: begin mul_a = ady; mul_b = apy; end
            MS_PLO: begin mul_a = nm_reg[MW-1:0]; mul_b = apz; end
            MS_PHI: begin mul_a = MW'(nm_reg[PRW:MW]); mul_b = apz; end
            default: ;
        endcase
    end

    nvdz_mul #(.MW(MW)) u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    nvdz_div #(.PW(PW), .RW(RW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (pt2_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // next state and datapath
    always_comb
    begin
        logic signed [DZW-1:0] qs, dz;
        logic [DZW-1:0]        dz_mag, kdz_mag;
        logic                  qneg, take;
        logic signed [CW-1:0]  ndof_x;
        logic [CW-1:0]         z_mag, r2_x;

        state_next = state_reg;
        step_next  = step_reg;
        r2_next    = r2_reg;
        pt2_next   = pt2_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        nm_next    = nm_reg;
        nn_next    = nn_reg;
        prod_next  = prod_reg;
        kx_next    = kx_reg;
        ky_next    = ky_reg;
        kz_next    = kz_reg;
        kdz_next   = kdz_reg;
        have_next  = have_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        odz_next   = odz_reg;
        of_next    = of_reg;
        div_start  = 1'b0;

        qneg    = nn_reg != pz_reg[W-1];
        qs      = qneg ? -DZW'(div_q) : DZW'(div_q);
        dz      = DZW'(lz_reg) - DZW'(z_reg) - qs;
        dz_mag  = dz[DZW-1] ? DZW'(-dz) : DZW'(dz);
        kdz_mag = kdz_reg[DZW-1] ? DZW'(-kdz_reg) : DZW'(kdz_reg);
        ndof_x  = CW'(ndof_reg);
        z_mag   = CW'(mag_f(MW'(z_reg)));
        r2_x    = CW'(r2_reg);
        take    = (ndof_x > NDOF_LIM) && (z_mag < Z_LIM) && (r2_x < R2_LIM)
                  && (pt2_reg != '0) && (dz_mag < kdz_mag);

        unique case (state_reg)
            S_IDLE:
            begin
                if (vtx.valid)
                begin
                    state_next = S_MUL;
                    step_next  = MS_XX;
                end
            end
            S_MUL:
            begin
                step_next = mstep_t'(step_reg + 4'd1);
                case (step_reg)
                    MS_XX:  r2_next  = RW'(mul_p);
                    MS_YY:  r2_next  = r2_reg + RW'(mul_p);
                    MS_PXX: pt2_next = RW'(mul_p);
                    MS_PYY: pt2_next = pt2_reg + RW'(mul_p);
                    MS_DXP:
                    begin
                        m1_next = mul_p;
                        n1_next = (dx_neg != px_reg[W-1]) && (mul_p != '0);
                    end
                    MS_DYP:
                    begin
                        m2_next = mul_p;
                        n2_next = (dy_neg != py_reg[W-1]) && (mul_p != '0);
                    end
                    MS_NUM:
                    begin
                        // signed sum of the two transverse products
                        if (n1_reg == n2_reg)
                        begin
                            nm_next = (PRW+1)'(m1_reg) + (PRW+1)'(m2_reg);
                            nn_next = n1_reg;
                        end
                        else if (m1_reg >= m2_reg)
                        begin
                            nm_next = (PRW+1)'(m1_reg - m2_reg);
                            nn_next = n1_reg;
                        end
                        else
                        begin
                            nm_next = (PRW+1)'(m2_reg - m1_reg);
                            nn_next = n2_reg;
                        end
                    end
                    MS_PLO: prod_next = PW'(mul_p);
                    MS_PHI:
                    begin
                        // hold the step so S_DIV can issue the start
                        prod_next  = prod_reg + (PW'(mul_p) << MW);
                        step_next  = MS_PHI;
                        state_next = S_DIV;
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                // divider start is issued on the first S_DIV cycle
                if (step_reg == MS_PHI)
                begin
                    div_start = 1'b1;
                    step_next = MS_XX;
                end
                else if (div_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (take)
                begin
                    kx_next   = x_reg;
                    ky_next   = y_reg;
                    kz_next   = z_reg;
                    kdz_next  = dz;
                    have_next = 1'b1;
                end
                if (last_reg)
                begin
                    ox_next   = kx_next;
                    oy_next   = ky_next;
                    oz_next   = kz_next;
                    odz_next  = W'(kdz_next);
                    of_next   = have_next;
                    kx_next   = '0;
                    ky_next   = '0;
                    kz_next   = '0;
                    kdz_next  = DZ_RST;
                    have_next = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= MS_XX;
            kx_reg    <= '0;
            ky_reg    <= '0;
            kz_reg    <= '0;
            kdz_reg   <= DZ_RST;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            kx_reg    <= kx_next;
            ky_reg    <= ky_next;
            kz_reg    <= kz_next;
            kdz_reg   <= kdz_next;
            have_reg  <= have_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && vtx.valid)
        begin
            x_reg    <= vtx.vtx_x;
            y_reg    <= vtx.vtx_y;
            z_reg    <= vtx.vtx_z;
            ndof_reg <= vtx.vtx_ndof;
            last_reg <= vtx.last;
        end
        r2_reg   <= r2_next;
        pt2_reg  <= pt2_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        n1_reg   <= n1_next;
        n2_reg   <= n2_next;
        nm_reg   <= nm_next;
        nn_reg   <= nn_next;
        prod_reg <= prod_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        odz_reg  <= odz_next;
        of_reg   <= of_next;
    end

    assign vtx.ready   = (state_reg == S_IDLE);
    assign res.valid   = (state_reg == S_OUT);
    assign res.best_x  = ox_reg;
    assign res.best_y  = oy_reg;
    assign res.best_z  = oz_reg;
    assign res.best_dz = odz_reg;
    assign res.found   = of_reg;
endmodule

/* tb/nearest_vertex_by_longitudinal_dz_tb.sv */
// Self-checking testbench for the nearest-vertex longitudinal dz selector.
module nearest_vertex_by_longitudinal_dz_tb;
    import nvdz_pkg::*;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT = 600000;
    localparam int STALL_START = 20000;
    localparam int STALL_CYCLES = 600;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] ndof;
        logic        last;
    } vertex_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] dz;
        logic        found;
    } choice_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [WORD_BITS-1:0]    cfg_data;

    nvdz_vtx_if #(.WORD_BITS(WORD_BITS)) vtx_ch ();
    nvdz_res_if #(.WORD_BITS(WORD_BITS)) res_ch ();

    nearest_vertex_by_longitudinal_dz #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .vtx      (vtx_ch),
        .res      (res_ch)
    );

    // predictor state: track line and the kept vertex
    longint  line_reg [6];
    longint  kept_x, kept_y, kept_z, kept_dz;
    bit      kept_valid;

    vertex_t pending_vertices[$];
    choice_t expected_choices[$];
    int      errors = 0;
    int      cycle_count = 0;
    bit      quiet;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit [63:0] magnitude(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint sext32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic void clear_kept();
        kept_x = 0;
        kept_y = 0;
        kept_z = 0;
        kept_dz = longint'(DZ_INIT) << FRAC_BITS;
        kept_valid = 0;
    endfunction

    // longitudinal distance of a vertex from the track line; 0 when pt is zero
    function automatic bit dz_of(longint x, longint y, longint z, output longint dz);
        longint px, py, pz, dx, dy;
        bit [63:0] pt2, m1, m2, nm, q;
        bit [127:0] prod, cap;
        bit n1, n2, nn, qneg;
        px = line_reg[REG_DIR_X];
        py = line_reg[REG_DIR_Y];
        pz = line_reg[REG_DIR_Z];
        pt2 = magnitude(px) * magnitude(px) + magnitude(py) * magnitude(py);
        dz = 0;
        if (pt2 == 0)
            return 0;
        dx = line_reg[REG_POINT_X] - x;
        dy = line_reg[REG_POINT_Y] - y;
        m1 = magnitude(dx) * magnitude(px);
        m2 = magnitude(dy) * magnitude(py);
        n1 = ((dx < 0) != (px < 0)) && m1 != 0;
        n2 = ((dy < 0) != (py < 0)) && m2 != 0;
        if (n1 == n2)
        begin
            nm = m1 + m2;
            nn = n1;
        end
        else if (m1 >= m2)
        begin
            nm = m1 - m2;
            nn = n1;
        end
        else
        begin
            nm = m2 - m1;
            nn = n2;
        end
        qneg = nn != (pz < 0);
        prod = {64'd0, nm} * {64'd0, magnitude(pz)};
        cap = {64'd0, pt2} << CAP_SHIFT;
        if (prod >= cap)
            q = 64'd1 << CAP_SHIFT;
        else
            q = 64'(prod / {64'd0, pt2});
        if (q == 0)
            qneg = 0;
        dz = (line_reg[REG_POINT_Z] - z) - (qneg ? -longint'(q) : longint'(q));
        return 1;
    endfunction

    // update the kept vertex; on a last word queue the expected choice
    function automatic void select_vertex(vertex_t v);
        longint x, y, z, ndof, dz;
        bit [63:0] r2;
        choice_t c;
        x = sext32(v.x);
        y = sext32(v.y);
        z = sext32(v.z);
        ndof = sext32(v.ndof);
        r2 = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y);
        if (ndof > (longint'(NDOF_MIN) << FRAC_BITS) &&
            magnitude(z) < (64'(Z_MAX) << FRAC_BITS) &&
            r2 < (64'(R2_MAX) << (2 * FRAC_BITS)) &&
            dz_of(x, y, z, dz) && magnitude(dz) < magnitude(kept_dz))
        begin
            kept_x = x;
            kept_y = y;
            kept_z = z;
            kept_dz = dz;
            kept_valid = 1;
        end
        if (v.last)
        begin
            c.x = kept_x[31:0];
            c.y = kept_y[31:0];
            c.z = kept_z[31:0];
            c.dz = kept_dz[31:0];
            c.found = kept_valid;
            expected_choices.insert(expected_choices.size(), c);
            clear_kept();
        end
    endfunction

    // vertex driver
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_ch.valid <= 1'b0;
            vtx_ch.vtx_x <= '0;
            vtx_ch.vtx_y <= '0;
            vtx_ch.vtx_z <= '0;
            vtx_ch.vtx_ndof <= '0;
            vtx_ch.last <= 1'b0;
            gap_left <= 0;
        end
        else if (!vtx_ch.valid || vtx_ch.ready)
        begin
            if (vtx_ch.valid)
                select_vertex('{vtx_ch.vtx_x, vtx_ch.vtx_y, vtx_ch.vtx_z,
                                vtx_ch.vtx_ndof, vtx_ch.last});
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                vtx_ch.valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(7) == 0)
            begin
                gap_left <= $urandom_range(2);
                vtx_ch.valid <= 1'b0;
            end
            else if (pending_vertices.size() > 0)
            begin
                vertex_t v;
                v = pending_vertices.pop_front();
                vtx_ch.vtx_x <= v.x;
                vtx_ch.vtx_y <= v.y;
                vtx_ch.vtx_z <= v.z;
                vtx_ch.vtx_ndof <= v.ndof;
                vtx_ch.last <= v.last;
                vtx_ch.valid <= 1'b1;
            end
            else
                vtx_ch.valid <= 1'b0;
        end
    end

    // result monitor with its own ready stalls
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_choices.size() == 0)
                begin
                    $error("unexpected result word");
                    errors++;
                end
                else
                begin
                    choice_t c;
                    c = expected_choices.pop_front();
                    if (res_ch.best_x !== c.x)
                    begin
                        $error("best_x: expected %h, got %h", c.x, res_ch.best_x);
                        errors++;
                    end
                    if (res_ch.best_y !== c.y)
                    begin
                        $error("best_y: expected %h, got %h", c.y, res_ch.best_y);
                        errors++;
                    end
                    if (res_ch.best_z !== c.z)
                    begin
                        $error("best_z: expected %h, got %h", c.z, res_ch.best_z);
                        errors++;
                    end
                    if (res_ch.best_dz !== c.dz)
                    begin
                        $error("best_dz: expected %h, got %h", c.dz, res_ch.best_dz);
                        errors++;
                    end
                    if (res_ch.found !== c.found)
                    begin
                        $error("found: expected %b, got %b", c.found, res_ch.found);
                        errors++;
                    end
                end
            end
            if (cycle_count == STALL_START)
            begin
                stall_left <= STALL_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(5) == 0)
            begin
                stall_left <= $urandom_range(2);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("nearest_vertex_by_longitudinal_dz: mismatch");
            $finish;
        end
    end

    function automatic int srange(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic void add_vertex(int x, int y, int z, int ndof, bit last);
        vertex_t v;
        v = '{x, y, z, ndof, last};
        pending_vertices.insert(pending_vertices.size(), v);
    endfunction

    // one register write, mirrored into the predictor
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx <= REG_DIR_Z)
            line_reg[idx] = sext32(data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_line(int lx, int ly, int lz, int px, int py, int pz);
        write_reg(REG_POINT_X, lx);
        write_reg(REG_POINT_Y, ly);
        write_reg(REG_POINT_Z, lz);
        write_reg(REG_DIR_X, px);
        write_reg(REG_DIR_Y, py);
        write_reg(REG_DIR_Z, pz);
    endtask

    // checked at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_vertices.size() > 0 || vtx_ch.valid || expected_choices.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random vertex lists: mostly plausible vertices, some raw noise
    task automatic random_lists(int count);
        int n, len;
        n = 0;
        while (n < count)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) == 0)
                    add_vertex($urandom, $urandom, $urandom, $urandom, i == len - 1);
                else
                    add_vertex(srange(2 * ONE), srange(2 * ONE), srange(26 * ONE),
                               $urandom_range(10 * ONE), i == len - 1);
            end
            n += len;
        end
    endtask

    initial
    begin
        quiet = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_POINT_X;
        cfg_data = '0;
        foreach (line_reg[i])
            line_reg[i] = 0;
        clear_kept();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset line: zero transverse direction selects nothing
        add_vertex(0, 0, 0, 5 * ONE, 1'b1);
        wait_drained();

        // directed: cut edges, ties, field extremes
        write_line(ONE / 2, -ONE / 4, ONE, ONE, ONE / 2, 2 * ONE);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        add_vertex(0, 0, 0, 4 * ONE, 1'b0);              // ndof at the cut
        add_vertex(ONE / 8, 0, ONE, 4 * ONE + 1, 1'b0);  // just passes
        add_vertex(ONE / 8, 0, ONE, 4 * ONE + 1, 1'b0);  // tie, first kept
        add_vertex(0, 0, 24 * ONE, 9 * ONE, 1'b0);       // z at the cut
        add_vertex(0, 0, -24 * ONE + 1, 9 * ONE, 1'b0);
        add_vertex(2 * ONE, 0, 0, 9 * ONE, 1'b1);        // radius at the cut
        add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_vertex(0, -2 * ONE + 1, 0, 32'h7FFF_FFFF, 1'b1);
        add_vertex(-ONE, ONE, -3 * ONE, 6 * ONE, 1'b0);
        add_vertex(ONE, -ONE, 3 * ONE, 6 * ONE, 1'b1);
        add_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // random phases over several line settings
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                2: write_line(srange(ONE), srange(ONE), srange(20 * ONE), 0, 0, srange(3 * ONE));
                4: write_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                5: write_line(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                7: write_line(srange(ONE), srange(ONE), srange(20 * ONE), 1, -1, srange(8 * ONE));
                default: write_line(srange(2 * ONE), srange(2 * ONE), srange(30 * ONE),
                                    srange(3 * ONE), srange(3 * ONE), srange(3 * ONE));
            endcase
            if (ph == 11)
                quiet = 1;
            random_lists(112);
            wait_drained();
        end

        if (errors == 0)
            $display("nearest_vertex_by_longitudinal_dz: match");
        else
            $display("nearest_vertex_by_longitudinal_dz: mismatch");
        $finish;
    end
endmodule

/* nearest_vertex_by_longitudinal_dz.f */
rtl/nvdz_pkg.sv
rtl/nvdz_if.sv
rtl/nvdz_mul.sv
rtl/nvdz_div.sv
rtl/nearest_vertex_by_longitudinal_dz.sv
tb/nearest_vertex_by_longitudinal_dz_tb.sv
